FILE: hw/rtl/s2i_pkg.sv
// Shared types, constants and helpers for the string-to-integer parser.
`default_nettype none
package s2i_pkg;

	localparam int MAX_DIGITS  = 16;
	localparam int ALPHA_CHARS = 16;
	localparam int CHAR_W      = 8;
	localparam int DIGIT_W     = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int BLEN_W      = 5;
	localparam int VALUE_W     = 32;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 64;
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LOW  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_HIGH = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEN   = CFG_IDX_W'(2);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

	typedef struct packed {
		logic [ALPHA_CHARS-1:0][CHAR_W-1:0] chars;
		logic [BLEN_W-1:0]                  base_len;
		logic                               alpha_ok;
	} s2i_cfg_t;

	typedef struct packed {
		logic               last;
		logic               white;
		logic               plus;
		logic               minus;
		logic               hit;
		logic [DIGIT_W-1:0] pos;
	} s2i_item_t;

	function automatic logic is_white(input logic [CHAR_W-1:0] c);
		return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/s2i_cfg.sv
// Configuration registers and registered alphabet validity check.
`default_nettype none
module s2i_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [s2i_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [s2i_pkg::CFG_DATA_W-1:0]     cfg_data,
	output s2i_pkg::s2i_cfg_t                       cfg
);

	logic [s2i_pkg::CFG_DATA_W-1:0] alpha_low_q;
	logic [s2i_pkg::CFG_DATA_W-1:0] alpha_high_q;
	logic [s2i_pkg::BLEN_W-1:0]     base_len_q;
	logic                           alpha_ok_q;
	logic                           alpha_ok;
	logic [s2i_pkg::ALPHA_CHARS-1:0][s2i_pkg::CHAR_W-1:0] chars;

	assign cfg_ready = 1'b1;
	assign chars = {alpha_high_q, alpha_low_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q  <= '0;
			alpha_high_q <= '0;
			base_len_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				s2i_pkg::CFG_ALPHA_LOW:  alpha_low_q  <= cfg_data;
				s2i_pkg::CFG_ALPHA_HIGH: alpha_high_q <= cfg_data;
				s2i_pkg::CFG_BASE_LEN:   base_len_q   <= cfg_data[s2i_pkg::BLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Reject short or long bases, reserved characters and duplicates
	always_comb begin
		logic [s2i_pkg::CHAR_W-1:0] c;
		c = '0;
		alpha_ok = (base_len_q >= s2i_pkg::BLEN_W'(2))
			&& (base_len_q <= s2i_pkg::BLEN_W'(s2i_pkg::MAX_DIGITS));
		for (int i = 0; i < s2i_pkg::MAX_DIGITS; i++) begin
			if (s2i_pkg::BLEN_W'(i) < base_len_q) begin
				c = chars[i];
				if (c == s2i_pkg::CH_NUL || c == s2i_pkg::CH_PLUS
						|| c == s2i_pkg::CH_MINUS || s2i_pkg::is_white(c))
					alpha_ok = 1'b0;
				for (int j = i + 1; j < s2i_pkg::MAX_DIGITS; j++) begin
					if (s2i_pkg::BLEN_W'(j) < base_len_q && chars[j] == c)
						alpha_ok = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_ok_q <= 1'b0;
		end else begin
			alpha_ok_q <= alpha_ok;
		end
	end

	assign cfg.chars    = chars;
	assign cfg.base_len = base_len_q;
	assign cfg.alpha_ok = alpha_ok_q;

endmodule
`default_nettype wire

FILE: hw/rtl/s2i_front.sv
// Front end: accepts characters and classifies them against the alphabet.
`default_nettype none
module s2i_front (
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire logic [s2i_pkg::CHAR_W-1:0]    ch,
	input  wire logic                          last,
	input  wire s2i_pkg::s2i_cfg_t             cfg,
	input  wire logic                          q_full,
	output logic                               push,
	output s2i_pkg::s2i_item_t                 item
);

	logic [s2i_pkg::MAX_DIGITS-1:0] match;

	assign in_stall = q_full;
	assign push     = in_valid && !in_stall;

	always_comb begin
		for (int i = 0; i < s2i_pkg::MAX_DIGITS; i++) begin
			match[i] = (s2i_pkg::BLEN_W'(i) < cfg.base_len) && (cfg.chars[i] == ch);
		end
	end

	// Lowest matching position wins
	always_comb begin
		item.last  = last;
		item.white = s2i_pkg::is_white(ch);
		item.plus  = (ch == s2i_pkg::CH_PLUS);
		item.minus = (ch == s2i_pkg::CH_MINUS);
		item.hit   = |match;
		item.pos   = '0;
		for (int i = s2i_pkg::MAX_DIGITS - 1; i >= 0; i--) begin
			if (match[i])
				item.pos = s2i_pkg::DIGIT_W'(i);
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/s2i_queue.sv
// Short queue of classified characters between front and back.
`default_nettype none
module s2i_queue (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	input  wire s2i_pkg::s2i_item_t push_item,
	output logic                    full,
	input  wire logic               pop,
	output s2i_pkg::s2i_item_t      head,
	output logic                    empty
);

	s2i_pkg::s2i_item_t entry_q [s2i_pkg::QUEUE_DEPTH];
	logic [s2i_pkg::QUEUE_AW-1:0] wr_ptr_q;
	logic [s2i_pkg::QUEUE_AW-1:0] rd_ptr_q;
	logic [s2i_pkg::QUEUE_CW-1:0] count_q;

	assign full  = (count_q == s2i_pkg::QUEUE_CW'(s2i_pkg::QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= s2i_pkg::QUEUE_CW'(s2i_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("pop from empty queue");

endmodule
`default_nettype wire

FILE: hw/rtl/s2i_back.sv
// Back end: parse phases, accumulator and registered result.
`default_nettype none
module s2i_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire s2i_pkg::s2i_cfg_t              cfg,
	input  wire s2i_pkg::s2i_item_t             item,
	input  wire logic                           empty,
	output logic                                pop,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic signed [s2i_pkg::VALUE_W-1:0]  value,
	output logic                                base_valid
);

	typedef enum logic [3:0] {
		PH_SPACE = 4'b0001,
		PH_SIGN  = 4'b0010,
		PH_DIGIT = 4'b0100,
		PH_DONE  = 4'b1000
	} phase_t;

	phase_t                        phase_q, phase_d;
	logic                          neg_q, neg_d;
	logic [s2i_pkg::VALUE_W-1:0]   acc_q, acc_d;
	logic [s2i_pkg::VALUE_W-1:0]   prod;
	logic [s2i_pkg::VALUE_W-1:0]   signed_acc;
	logic                          in_sign;
	logic                          in_digit;
	logic                          out_valid_q;
	logic [s2i_pkg::VALUE_W-1:0]   value_q;
	logic                          base_valid_q;

	assign pop  = !empty && (!out_valid_q || !out_stall);
	assign prod = s2i_pkg::VALUE_W'(acc_q * s2i_pkg::VALUE_W'(cfg.base_len));

	// A character can fall through several phases in one step
	always_comb begin
		phase_d  = phase_q;
		neg_d    = neg_q;
		acc_d    = acc_q;
		in_sign  = 1'b0;
		in_digit = 1'b0;
		unique case (phase_q)
			PH_SPACE: in_sign  = !item.white;
			PH_SIGN:  in_sign  = 1'b1;
			PH_DIGIT: in_digit = 1'b1;
			PH_DONE:  ;
			default:  ;
		endcase
		if (in_sign) begin
			if (item.minus) begin
				neg_d   = ~neg_q;
				phase_d = PH_SIGN;
			end else if (item.plus) begin
				phase_d = PH_SIGN;
			end else begin
				in_digit = 1'b1;
			end
		end
		if (in_digit) begin
			if (item.hit) begin
				acc_d   = prod + s2i_pkg::VALUE_W'(item.pos);
				phase_d = PH_DIGIT;
			end else begin
				phase_d = PH_DONE;
			end
		end
		signed_acc = neg_d ? (s2i_pkg::VALUE_W'(0) - acc_d) : acc_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SPACE;
			neg_q   <= 1'b0;
			acc_q   <= '0;
		end else if (pop) begin
			if (item.last) begin
				phase_q <= PH_SPACE;
				neg_q   <= 1'b0;
				acc_q   <= '0;
			end else begin
				phase_q <= phase_d;
				neg_q   <= neg_d;
				acc_q   <= acc_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && item.last) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && item.last) begin
			value_q      <= cfg.alpha_ok ? signed_acc : '0;
			base_valid_q <= cfg.alpha_ok;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = signed'(value_q);
	assign base_valid = base_valid_q;

	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && item.last) |=> (phase_q == PH_SPACE && !neg_q && acc_q == '0))
		else $error("parser not restarted after last character");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !base_valid_q) |-> (value_q == '0))
		else $error("nonzero value with invalid alphabet");

	a_done_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DONE) |=> (phase_q == PH_DONE || phase_q == PH_SPACE))
		else $error("parsing resumed after stop");

endmodule
`default_nettype wire

FILE: hw/rtl/string_to_int_any_base_core.sv
// Top level of the string-to-integer parser with a configurable alphabet.
//
// Takes one character per cycle while the queue is not full and returns one
// result per string on the character flagged last. The back end does one
// multiply-add by base_length per character, one per cycle unless the output
// is stalled. An accepted character is classified and written into the
// queue; the back end parses it at the queue head and, on the character
// flagged last, writes the result to the output register. A four-entry queue
// parts the front end from the back end, so input is taken while a result
// waits. The registered alphabet validity flag updates in the cycle after a
// configuration write; write configuration only while no string is in flight.
`default_nettype none
module string_to_int_any_base_core (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [s2i_pkg::CHAR_W-1:0]         ch,
	input  wire logic                               last,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic signed [s2i_pkg::VALUE_W-1:0]      value,
	output logic                                    base_valid,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [s2i_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [s2i_pkg::CFG_DATA_W-1:0]     cfg_data
);

	s2i_pkg::s2i_cfg_t  cfg;
	s2i_pkg::s2i_item_t front_item;
	s2i_pkg::s2i_item_t head_item;
	logic               push;
	logic               pop;
	logic               q_full;
	logic               q_empty;

	s2i_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	s2i_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.ch       (ch),
		.last     (last),
		.cfg      (cfg),
		.q_full   (q_full),
		.push     (push),
		.item     (front_item)
	);

	s2i_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (front_item),
		.full      (q_full),
		.pop       (pop),
		.head      (head_item),
		.empty     (q_empty)
	);

	s2i_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.item       (head_item),
		.empty      (q_empty),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.base_valid (base_valid)
	);

endmodule
`default_nettype wire
